[rtl/centred_block_average_mosaic_macros.svh]
// Assertion macros used by the cbam_props checker.
`ifndef CENTRED_BLOCK_AVERAGE_MOSAIC_MACROS_SVH
`define CENTRED_BLOCK_AVERAGE_MOSAIC_MACROS_SVH

// Check a consequence in the same cycle, skipped during reset.
`define CBAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the next cycle, skipped during reset.
`define CBAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check a consequence in the next cycle, also across reset.
`define CBAM_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cbam_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbam_pkg
// Shared types and constants of the centred block-average mosaic.
// ----------------------------------------------------------------------------
package cbam_pkg;

  localparam int SUM_W  = 24;
  localparam int PIX_W  = 8;
  localparam int CNT_W  = 17;
  localparam int BLK_W  = 9;
  localparam int DIM_W  = 12;
  localparam int TCI_W  = 10;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [BLK_W-1:0] RST_BLOCK_SIZE   = 9'd3;
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 12'd480;
  localparam logic [BLK_W-1:0] MIN_BLOCK        = 9'd3;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

endpackage

[rtl/centred_block_average_mosaic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centred_block_average_mosaic
// Tile averages over a grid centred on the frame, sums kept per tile column.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in        sink       in_valid/in_stall   red_in green_in blue_in
//  out       source     out_valid/out_stall tile_x..frame_done
//  cfg       sink       wr_en               wr_index wr_data
//
//  A pixel passes S_READ (S_EMIT in passthrough); a pixel that closes a tile
//  then passes S_MUL, S_DIV (bit-serial divider of the channel means), S_EMIT.
//  After reset or a register write in_stall stays high while the grid phase
//  unit works out its 11 quotient bits (log2 of MAX_WIDTH).
//  in_stall stays high until the accepted pixel and any tile it closes are done.
// ----------------------------------------------------------------------------
module centred_block_average_mosaic import cbam_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_BLOCK  = 256,
  parameter int TILE_SLOTS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [DIM_W-1:0] wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       red_in,
  input  logic [7:0]       green_in,
  input  logic [7:0]       blue_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [10:0]      tile_x,
  output logic [10:0]      tile_y,
  output logic [8:0]       tile_w,
  output logic [8:0]       tile_h,
  output logic [7:0]       red_avg,
  output logic [7:0]       green_avg,
  output logic [7:0]       blue_avg,
  output logic             frame_done
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int PH_W   = $clog2(MAX_BLOCK);
  localparam int SLOT_W = $clog2(TILE_SLOTS);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]       state;
  logic [BLK_W-1:0] block_size;
  logic [DIM_W-1:0] frame_width, frame_height;
  logic             phase_go;
  logic [XW-1:0]    x, y;
  logic [PH_W-1:0]  cp, lp, col_start, line_start;
  logic [TCI_W-1:0] tci;
  logic [SLOT_W-1:0] slot, slot_r;
  pix_t             pix;
  logic             first_r, emit_r, done_r;
  logic [XW-1:0]    res_x, res_y;
  logic [BLK_W-1:0] res_w, res_h;
  pix_t             res_avg;
  sums_t            rd_sums, new_sums, sum_r;
  logic             div_done;
  pix_t             div_avg;
  logic             ph_done;
  logic [PH_W-1:0]  ph_col, ph_line;

  logic [BLK_W-1:0] blk;
  logic [WW-1:0]    w_eff, h_eff;
  logic             pass, accept, last_x, last_y, col_first, line_first;
  logic             col_last, line_last, out_free, cfg_hit, emit_go;
  logic [XW-1:0]    tx, ty;
  logic [BLK_W-1:0] tw, th;

  always_comb begin
    blk = (int'(block_size) > MAX_BLOCK) ? BLK_W'(MAX_BLOCK) : block_size;
    if (frame_width < DIM_W'(2)) w_eff = WW'(2);
    else if (int'(frame_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(frame_width);
    if (frame_height < DIM_W'(2)) h_eff = WW'(2);
    else if (int'(frame_height) > MAX_WIDTH) h_eff = WW'(MAX_WIDTH);
    else h_eff = WW'(frame_height);
    pass       = blk < MIN_BLOCK;
    last_x     = WW'(x) >= w_eff - 1'b1;
    last_y     = WW'(y) >= h_eff - 1'b1;
    col_first  = (cp == '0) || (x == '0);
    line_first = (lp == '0) || (y == '0);
    col_last   = (BLK_W'(cp) >= blk - 1'b1) || last_x;
    line_last  = (BLK_W'(lp) >= blk - 1'b1) || last_y;
    tx         = (x >= XW'(cp)) ? x - XW'(cp) : '0;
    ty         = (y >= XW'(lp)) ? y - XW'(lp) : '0;
    tw         = BLK_W'(x - tx + 1'b1);
    th         = BLK_W'(y - ty + 1'b1);
    in_stall   = state != S_IDLE;
    accept     = in_valid && !in_stall;
    out_free   = !out_valid || !out_stall;
    cfg_hit    = wr_en && (wr_index == REG_BLOCK_SIZE || wr_index == REG_FRAME_WIDTH ||
                           wr_index == REG_FRAME_HEIGHT);
    emit_go    = !cfg_hit && state == S_EMIT && out_free;
  end

  assign new_sums.red   = first_r ? SUM_W'(pix.red)   : rd_sums.red   + SUM_W'(pix.red);
  assign new_sums.green = first_r ? SUM_W'(pix.green) : rd_sums.green + SUM_W'(pix.green);
  assign new_sums.blue  = first_r ? SUM_W'(pix.blue)  : rd_sums.blue  + SUM_W'(pix.blue);

  cbam_sums #(.SLOTS(TILE_SLOTS), .SLOT_W(SLOT_W)) u_sums (
    .clk     (clk),
    .wr_en   (state == S_READ),
    .wr_addr (slot_r),
    .wr_data (new_sums),
    .rd_en   (accept),
    .rd_addr (slot),
    .rd_data (rd_sums)
  );

  cbam_phase #(.WW(WW), .PH_W(PH_W)) u_phase (
    .clk        (clk),
    .rst        (rst),
    .go         (phase_go),
    .width      (w_eff),
    .height     (h_eff),
    .blk        (blk),
    .done       (ph_done),
    .col_phase  (ph_col),
    .line_phase (ph_line)
  );

  cbam_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_MUL),
    .sums  (sum_r),
    .count (CNT_W'(res_w * res_h)),
    .done  (div_done),
    .avg   (div_avg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= RST_BLOCK_SIZE;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      state        <= S_INIT;
      phase_go     <= 1'b1;
      x            <= '0;
      y            <= '0;
      tci          <= '0;
      slot         <= '0;
    end else begin
      phase_go <= 1'b0;
      if (cfg_hit) begin
        unique case (wr_index)
          REG_BLOCK_SIZE:  block_size   <= wr_data[BLK_W-1:0];
          REG_FRAME_WIDTH: frame_width  <= wr_data;
          default:         frame_height <= wr_data;
        endcase
        state    <= S_INIT;
        phase_go <= 1'b1;
        x        <= '0;
        y        <= '0;
        tci      <= '0;
        slot     <= '0;
      end else begin
        unique case (state)
          S_INIT: begin
            if (ph_done && !phase_go) begin
              col_start  <= ph_col;
              line_start <= ph_line;
              cp         <= ph_col;
              lp         <= ph_line;
              state      <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              pix     <= '{red: red_in, green: green_in, blue: blue_in};
              first_r <= col_first && line_first;
              emit_r  <= col_last && line_last;
              done_r  <= last_x && last_y;
              slot_r  <= slot;
              if (pass) begin
                res_x   <= x;
                res_y   <= y;
                res_w   <= BLK_W'(1);
                res_h   <= BLK_W'(1);
                res_avg <= '{red: red_in, green: green_in, blue: blue_in};
                cp      <= '0;
                lp      <= '0;
                tci     <= '0;
                slot    <= '0;
                state   <= S_EMIT;
              end else begin
                res_x <= tx;
                res_y <= ty;
                res_w <= tw;
                res_h <= th;
                state <= S_READ;
              end
              if (last_x) begin
                x <= '0;
                y <= last_y ? '0 : y + 1'b1;
                if (!pass) begin
                  cp   <= col_start;
                  tci  <= '0;
                  slot <= '0;
                  if (last_y) lp <= line_start;
                  else lp <= (BLK_W'(lp) >= blk - 1'b1) ? '0 : lp + 1'b1;
                end
              end else begin
                x <= x + 1'b1;
                if (!pass) begin
                  if (col_last) begin
                    cp  <= '0;
                    tci <= tci + 1'b1;
                    if (int'(slot) == TILE_SLOTS - 1 || tci == '1) slot <= '0;
                    else slot <= slot + 1'b1;
                  end else begin
                    cp <= cp + 1'b1;
                  end
                end
              end
            end
          end
          S_READ: begin
            sum_r <= new_sums;
            state <= emit_r ? S_MUL : S_IDLE;
          end
          S_MUL: begin
            state <= S_DIV;
          end
          S_DIV: begin
            if (div_done) begin
              res_avg <= div_avg;
              state   <= S_EMIT;
            end
          end
          S_EMIT: begin
            if (out_free) begin
              tile_x     <= 11'(res_x);
              tile_y     <= 11'(res_y);
              tile_w     <= res_w;
              tile_h     <= res_h;
              red_avg    <= res_avg.red;
              green_avg  <= res_avg.green;
              blue_avg   <= res_avg.blue;
              frame_done <= done_r;
              state      <= S_IDLE;
            end
          end
          default: state <= S_INIT;
        endcase
      end
    end
  end

endmodule

[rtl/cbam_sums.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbam_sums
// Per tile-column channel sums, one write and one registered read port.
// ----------------------------------------------------------------------------
module cbam_sums import cbam_pkg::*; #(
  parameter int SLOTS  = 1024,
  parameter int SLOT_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_addr,
  input  sums_t             wr_data,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output sums_t             rd_data
);

  sums_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/cbam_phase.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbam_phase
// Grid phase at column/line zero: -(n/2) mod b, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cbam_phase import cbam_pkg::*; #(
  parameter int WW   = 12,
  parameter int PH_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [WW-1:0]    width,
  input  logic [WW-1:0]    height,
  input  logic [BLK_W-1:0] blk,
  output logic             done,
  output logic [PH_W-1:0]  col_phase,
  output logic [PH_W-1:0]  line_phase
);

  localparam int DW  = WW - 1;
  localparam int CW  = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] wq, hq;
  logic [BLK_W-1:0] wrem, hrem;
  logic [BLK_W:0]   wsh, hsh;

  assign wsh = {wrem, wq[DW-1]};
  assign hsh = {hrem, hq[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
        wq   <= width[WW-1:1];
        hq   <= height[WW-1:1];
        wrem <= '0;
        hrem <= '0;
      end else if (busy) begin
        wq   <= {wq[DW-2:0], 1'b0};
        hq   <= {hq[DW-2:0], 1'b0};
        wrem <= (wsh >= {1'b0, blk}) ? BLK_W'(wsh - {1'b0, blk}) : wsh[BLK_W-1:0];
        hrem <= (hsh >= {1'b0, blk}) ? BLK_W'(hsh - {1'b0, blk}) : hsh[BLK_W-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (blk < MIN_BLOCK || wrem == '0) col_phase = '0;
    else col_phase = PH_W'(blk - wrem);
    if (blk < MIN_BLOCK || hrem == '0) line_phase = '0;
    else line_phase = PH_W'(blk - hrem);
  end

endmodule

[rtl/cbam_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbam_div
// Three channel sums divided by the tile pixel count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cbam_div import cbam_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sums_t            sums,
  input  logic [CNT_W-1:0] count,
  output logic             done,
  output pix_t             avg
);

  localparam int RW = SUM_W + 1;

  logic       busy;
  logic [2:0] bitn;
  logic [CNT_W-1:0] n;
  logic [RW-1:0] rr, rg, rb, dsh;

  assign dsh = RW'({n, 7'b0}) >> (3'd7 - bitn);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bitn <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bitn <= 3'd7;
        n    <= count;
        rr   <= RW'(sums.red);
        rg   <= RW'(sums.green);
        rb   <= RW'(sums.blue);
      end else if (busy) begin
        avg.red   <= {avg.red[PIX_W-2:0], rr >= dsh};
        avg.green <= {avg.green[PIX_W-2:0], rg >= dsh};
        avg.blue  <= {avg.blue[PIX_W-2:0], rb >= dsh};
        if (rr >= dsh) rr <= rr - dsh;
        if (rg >= dsh) rg <= rg - dsh;
        if (rb >= dsh) rb <= rb - dsh;
        bitn <= bitn - 1'b1;
        if (bitn == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/cbam_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbam_props
// Port-level checks of the centred block-average mosaic.
// ----------------------------------------------------------------------------
`include "centred_block_average_mosaic_macros.svh"

module cbam_props import cbam_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             wr_en,
  input logic [IDX_W-1:0] wr_index,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [8:0]       tile_w,
  input logic [8:0]       tile_h
);

  `CBAM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "item dropped while stalled")
  `CBAM_ASSERT_NOW(a_tile_size, out_valid, tile_w != 9'd0 && tile_h != 9'd0, "empty tile")
  `CBAM_ASSERT_ALWAYS_NEXT(a_rst_quiet, rst, !out_valid && in_stall, "activity after reset")
  `CBAM_ASSERT_NEXT(a_cfg_stall, wr_en && wr_index <= REG_FRAME_HEIGHT, in_stall, "pixel taken during grid restart")

endmodule

bind centred_block_average_mosaic cbam_props u_cbam_props (.*);

[tb/cbam_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbam_checker
// Watches the register port and both channels of the centred block-average
// mosaic, tracks pixel position, grid phase and per-column channel sums, and
// compares every accepted tile with the oldest predicted one.
// ----------------------------------------------------------------------------
module cbam_checker import cbam_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [DIM_W-1:0] wr_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       red_in,
  input  logic [7:0]       green_in,
  input  logic [7:0]       blue_in,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [10:0]      tile_x,
  input  logic [10:0]      tile_y,
  input  logic [8:0]       tile_w,
  input  logic [8:0]       tile_h,
  input  logic [7:0]       red_avg,
  input  logic [7:0]       green_avg,
  input  logic [7:0]       blue_avg,
  input  logic             frame_done,
  output int               mismatches,
  output int               pending
);

  localparam int MAX_DIM   = 2048;
  localparam int MAX_BLK   = 256;
  localparam int SLOTS     = 1024;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        done;
  } tile_t;

  logic [BLK_W-1:0] blk;
  logic [DIM_W-1:0] fw;
  logic [DIM_W-1:0] fh;
  int col, line, tci, col_ph, line_ph;
  logic [SUM_W-1:0] red_sum [SLOTS];
  logic [SUM_W-1:0] green_sum [SLOTS];
  logic [SUM_W-1:0] blue_sum [SLOTS];
  tile_t tiles_due [$];

  function automatic int pitch();
    return (blk > MAX_BLK) ? MAX_BLK : int'(blk);
  endfunction

  function automatic int dim_clamp(logic [DIM_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic int grid_phase(int n, int b);
    int r;
    if (b < 3) return 0;
    r = (n / 2) % b;
    return (r == 0) ? 0 : b - r;
  endfunction

  function automatic void restart_frame();
    col = 0;
    line = 0;
    tci = 0;
    col_ph = grid_phase(dim_clamp(fw), pitch());
    line_ph = grid_phase(dim_clamp(fh), pitch());
  endfunction

  function automatic bit take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] bl,
                                    output tile_t t);
    int b, w, h, x, y, slot, tx, ty, tw, th, n;
    bit last_x, last_y, col_first, line_first, col_last, line_last, hit;
    b = pitch();
    w = dim_clamp(fw);
    h = dim_clamp(fh);
    x = col;
    y = line;
    last_x = (x >= w - 1);
    last_y = (y >= h - 1);
    hit = 0;
    t = '0;
    if (b < 3) begin
      t.x = x[10:0];
      t.y = y[10:0];
      t.w = 9'd1;
      t.h = 9'd1;
      t.red = r;
      t.green = g;
      t.blue = bl;
      t.done = last_x && last_y;
      if (last_x) begin
        col = 0;
        line = last_y ? 0 : y + 1;
      end else begin
        col = x + 1;
      end
      col_ph = 0;
      line_ph = 0;
      tci = 0;
      return 1;
    end
    slot = tci % SLOTS;
    col_first = (col_ph == 0) || (x == 0);
    line_first = (line_ph == 0) || (y == 0);
    col_last = (col_ph >= b - 1) || last_x;
    line_last = (line_ph >= b - 1) || last_y;
    if (col_first && line_first) begin
      red_sum[slot] = r;
      green_sum[slot] = g;
      blue_sum[slot] = bl;
    end else begin
      red_sum[slot] = red_sum[slot] + r;
      green_sum[slot] = green_sum[slot] + g;
      blue_sum[slot] = blue_sum[slot] + bl;
    end
    if (col_last && line_last) begin
      tx = (x >= col_ph) ? x - col_ph : 0;
      ty = (y >= line_ph) ? y - line_ph : 0;
      tw = x - tx + 1;
      th = y - ty + 1;
      n = tw * th;
      t.x = tx[10:0];
      t.y = ty[10:0];
      t.w = tw[8:0];
      t.h = th[8:0];
      t.red = 8'(int'(red_sum[slot]) / n);
      t.green = 8'(int'(green_sum[slot]) / n);
      t.blue = 8'(int'(blue_sum[slot]) / n);
      t.done = last_x && last_y;
      hit = 1;
    end
    if (last_x) begin
      col = 0;
      col_ph = grid_phase(w, b);
      tci = 0;
      if (last_y) begin
        line = 0;
        line_ph = grid_phase(h, b);
      end else begin
        line = y + 1;
        line_ph = (line_ph >= b - 1) ? 0 : line_ph + 1;
      end
    end else begin
      col = x + 1;
      if (col_last) begin
        col_ph = 0;
        tci = (tci + 1) & 10'h3FF;
      end else begin
        col_ph = col_ph + 1;
      end
    end
    return hit;
  endfunction

  function automatic void flag(tile_t e, tile_t a, bit stray);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      if (stray)
        $display("tile with none expected: x=%0d y=%0d w=%0d h=%0d rgb=%0d,%0d,%0d done=%0b",
                 a.x, a.y, a.w, a.h, a.red, a.green, a.blue, a.done);
      else
        $display("tile mismatch: exp x=%0d y=%0d w=%0d h=%0d rgb=%0d,%0d,%0d done=%0b / act x=%0d y=%0d w=%0d h=%0d rgb=%0d,%0d,%0d done=%0b",
                 e.x, e.y, e.w, e.h, e.red, e.green, e.blue, e.done,
                 a.x, a.y, a.w, a.h, a.red, a.green, a.blue, a.done);
    end
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch
    tile_t got, want;
    if (rst) begin
      blk = RST_BLOCK_SIZE;
      fw = RST_FRAME_WIDTH;
      fh = RST_FRAME_HEIGHT;
      restart_frame();
      tiles_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {tile_x, tile_y, tile_w, tile_h, red_avg, green_avg, blue_avg, frame_done};
        if (tiles_due.size() == 0) begin
          flag(got, got, 1);
        end else begin
          want = tiles_due.pop_front();
          if (want.x != got.x || want.y != got.y || want.w != got.w ||
              want.h != got.h || want.red != got.red || want.green != got.green ||
              want.blue != got.blue || want.done != got.done)
            flag(want, got, 0);
        end
      end
      if (wr_en) begin
        case (wr_index)
          REG_BLOCK_SIZE: begin
            blk = wr_data[BLK_W-1:0];
            restart_frame();
          end
          REG_FRAME_WIDTH: begin
            fw = wr_data;
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            fh = wr_data;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (take_pixel(red_in, green_in, blue_in, want))
          tiles_due.push_back(want);
      end
    end
    pending = tiles_due.size();
  end

endmodule

[tb/centred_block_average_mosaic_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centred_block_average_mosaic_tb
// Streams RGB frames through the mosaic under a series of tile and frame
// settings, directed corners around a run of random frames, with random
// gaps on the pixel side and random stalls on the tile side.
// ----------------------------------------------------------------------------
module centred_block_average_mosaic_tb;
  import cbam_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_PIXELS = 1730;
  localparam int SETTLE = 40;

  logic             clk;
  logic             rst;
  logic             wr_en;
  logic [IDX_W-1:0] wr_index;
  logic [DIM_W-1:0] wr_data;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       red_in;
  logic [7:0]       green_in;
  logic [7:0]       blue_in;
  logic             out_valid;
  logic             out_stall;
  logic [10:0]      tile_x;
  logic [10:0]      tile_y;
  logic [8:0]       tile_w;
  logic [8:0]       tile_h;
  logic [7:0]       red_avg;
  logic [7:0]       green_avg;
  logic [7:0]       blue_avg;
  logic             frame_done;
  int               mismatches;
  int               pending;
  bit               in_quiet;
  bit               out_quiet;
  int               sent;

  centred_block_average_mosaic u_top (.*);

  cbam_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    out_stall = 1'b1;
    @(negedge rst);
    forever begin : drain
      int n;
      n = out_quiet ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic drain_tiles();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_grid(int bs, int w, int h, bit poke_unused);
    drain_tiles();
    repeat (SETTLE) @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_BLOCK_SIZE;
    wr_data <= {3'($urandom), 9'(bs)};
    @(posedge clk);
    wr_index <= REG_FRAME_WIDTH;
    wr_data <= 12'(w);
    @(posedge clk);
    wr_index <= REG_FRAME_HEIGHT;
    wr_data <= 12'(h);
    @(posedge clk);
    if (poke_unused) begin
      wr_index <= REG_UNUSED;
      wr_data <= 12'($urandom);
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  task automatic send_random(int n, bit pause);
    int stop_at;
    stop_at = pause ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == stop_at) drain_tiles();
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int bs, w, h, pw, ph, frames, extra, pick, cnt;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_BLOCK_SIZE;
    wr_data = '0;
    in_valid = 1'b0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    in_quiet = 0;
    out_quiet = 0;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_grid(1, 2, 2, 0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    set_grid(0, 1, 1, 0);
    send_random(3, 0);
    set_grid(2, 3, 2, 0);
    send_random(6, 0);
    set_grid(300, 0, 3, 0);
    send_random(6, 0);
    set_grid(3, 5, 4, 1);
    for (int i = 0; i < 20; i++) send_pixel(8'd255, 8'd255, 8'd255);

    set_grid(256, 700, 0, 0);
    in_quiet = 1;
    out_quiet = 1;
    send_random(700, 1);

    while (sent < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) bs = $urandom_range(0, 2);
      else if (pick == 2) bs = $urandom_range(9, 511);
      else bs = $urandom_range(3, 8);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 24);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 16);
      pw = (w < 2) ? 2 : w;
      ph = (h < 2) ? 2 : h;
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      set_grid(bs, w, h, $urandom_range(0, 4) == 0);
      frames = $urandom_range(1, 2);
      extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, pw * ph / 2) : 0;
      cnt = frames * pw * ph + extra;
      if (cnt > RANDOM_PIXELS - sent) cnt = RANDOM_PIXELS - sent;
      send_random(cnt, $urandom_range(0, 3) == 0);
    end
    set_grid(4095, 4095, 4095, 1);
    send_random(20, 0);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
